// ===== hw/rtl/tts_pkg.sv =====
// Package for the TFTP transfer sequencer: beat layouts, event and action
// codes, packet opcodes, configuration indexes and reset values.
// No dependencies.
`default_nettype none

package tts_pkg;

  typedef enum logic [1:0] {
    OP_PACKET  = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_START   = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_SEND_ACK  = 2'd1,
    ACT_SEND_DATA = 2'd2,
    ACT_RESEND    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_PEER       = 2'd1,
    ERR_UNEXPECTED = 2'd2,
    ERR_RSVD       = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    CFG_DIRECTION   = 2'd0,
    CFG_BLOCK_SIZE  = 2'd1,
    CFG_FILE_SIZE   = 2'd2,
    CFG_MAIN_CLIENT = 2'd3
  } cfg_idx_e;

  localparam logic [15:0] OPC_DATA  = 16'd3;
  localparam logic [15:0] OPC_ACK   = 16'd4;
  localparam logic [15:0] OPC_ERROR = 16'd5;
  localparam logic [15:0] OPC_OACK  = 16'd6;

  localparam logic [15:0] BlockSizeMin   = 16'd8;
  localparam logic [15:0] BlockSizeReset = 16'd512;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 72;

  // Input beat payload, lowest field in the lowest bits.
  typedef struct packed {
    logic [15:0] payload_bytes;
    logic [15:0] packet_block;
    logic [15:0] packet_opcode;
  } in_beat_t;

  // Result beat payload, lowest field in the lowest bits, padded to 9 bytes.
  typedef struct packed {
    logic [1:0]  pad;
    err_e        error_code;
    logic        transfer_done;
    logic        accept_payload;
    logic [15:0] data_length;
    logic [31:0] data_offset;
    logic [15:0] out_block;
    action_e     action;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tftp_transfer_sequencer_top.sv =====
// Lock-step TFTP client transfer sequencer, top level.
// A beat is captured in the input register and then in the result register.
// Throughput: one beat per cycle while the result stream takes beats; the
// 16x16 offset multiply sits between the input register and the result register and sets the cycle time.
// Reset: configuration returns to its defaults, the transfer state clears,
// and both pipeline registers empty.
// Depends on tts_pkg.
`default_nettype none

module tftp_transfer_sequencer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [tts_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Event stream
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: packet_opcode[15:0], packet_block[31:16], payload_bytes[47:32]
  input  wire logic [tts_pkg::InDataW-1:0]   s_axis_tdata_i,
  // tuser: op[1:0]
  input  wire logic [1:0]                    s_axis_tuser_i,
  // Result stream
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // tdata: action[1:0], out_block[17:2], data_offset[49:18], data_length[65:50],
  //        accept_payload[66], transfer_done[67], error_code[69:68], zero pad[71:70]
  output logic [tts_pkg::OutDataW-1:0]       m_axis_tdata_o
);
  import tts_pkg::*;

  // Configuration registers
  logic        cfg_direction_q;
  logic [15:0] cfg_block_size_q;
  logic [31:0] cfg_file_size_q;
  logic        cfg_main_client_q;

  // Transfer state
  logic [15:0] exp_block_q, exp_block_d;
  logic        finished_q, finished_d;
  logic        failed_q, failed_d;

  // Pipeline registers
  logic      in_valid_q;
  in_beat_t  in_q;
  op_e       in_op_q;
  logic      out_valid_q;
  out_beat_t out_q, out_d;

  logic        out_free;
  logic        in_fire;
  logic        step;
  logic [15:0] bs_eff;
  logic [31:0] product;
  logic [31:0] offset;
  logic [31:0] left;
  logic [16:0] next_blk;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign step            = in_valid_q && out_free;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_direction_q   <= 1'b0;
      cfg_block_size_q  <= BlockSizeReset;
      cfg_file_size_q   <= '0;
      cfg_main_client_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DIRECTION:   cfg_direction_q   <= cfg_wdata_i[0];
        CFG_BLOCK_SIZE:  cfg_block_size_q  <= cfg_wdata_i[15:0];
        CFG_FILE_SIZE:   cfg_file_size_q   <= cfg_wdata_i;
        CFG_MAIN_CLIENT: cfg_main_client_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      exp_block_q <= '0;
      finished_q  <= 1'b0;
      failed_q    <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        exp_block_q <= exp_block_d;
        finished_q  <= finished_d;
        failed_q    <= failed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q    <= in_beat_t'(s_axis_tdata_i);
      in_op_q <= op_e'(s_axis_tuser_i);
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  // Write direction: the block after ACK n starts at n * block size, and the
  // transfer is over once that offset reaches the file size.
  assign bs_eff   = (cfg_block_size_q < BlockSizeMin) ? BlockSizeMin : cfg_block_size_q;
  assign product  = 32'(in_q.packet_block) * 32'(bs_eff);
  assign next_blk = (in_q.packet_opcode == OPC_ACK) ? ({1'b0, in_q.packet_block} + 17'd1)
                                                   : 17'd1;
  assign offset   = (in_q.packet_opcode == OPC_ACK) ? product : '0;
  assign left     = cfg_file_size_q - offset;

  always_comb begin
    out_d       = '0;
    exp_block_d = exp_block_q;
    finished_d  = finished_q;
    failed_d    = failed_q;
    if (in_op_q == OP_START) begin
      finished_d  = 1'b0;
      failed_d    = 1'b0;
      exp_block_d = cfg_direction_q ? 16'd0 : 16'd1;
    end else if (in_op_q == OP_UNUSED || finished_q || failed_q) begin
      out_d = '0;
    end else if (in_op_q == OP_TIMEOUT) begin
      out_d.action = ACT_RESEND;
    end else if (in_q.packet_opcode == OPC_ERROR) begin
      failed_d         = 1'b1;
      out_d.error_code = ERR_PEER;
    end else if (!cfg_direction_q) begin
      case (in_q.packet_opcode)
        OPC_OACK: begin
          out_d.action = ACT_SEND_ACK;
          exp_block_d  = 16'd1;
        end
        OPC_DATA: begin
          if (in_q.packet_block != exp_block_q) begin
            out_d.action = ACT_RESEND;
          end else begin
            out_d.accept_payload = 1'b1;
            if (cfg_main_client_q) begin
              out_d.action    = ACT_SEND_ACK;
              out_d.out_block = exp_block_q;
            end
            exp_block_d = exp_block_q + 16'd1;
            if (in_q.payload_bytes < bs_eff) begin
              finished_d          = 1'b1;
              out_d.transfer_done = 1'b1;
            end
          end
        end
        default: begin
          failed_d         = 1'b1;
          out_d.error_code = ERR_UNEXPECTED;
        end
      endcase
    end else if (in_q.packet_opcode == OPC_ACK || in_q.packet_opcode == OPC_OACK) begin
      exp_block_d = next_blk[15:0];
      if (offset >= cfg_file_size_q) begin
        finished_d          = 1'b1;
        out_d.transfer_done = 1'b1;
      end else begin
        out_d.action      = ACT_SEND_DATA;
        out_d.out_block   = next_blk[15:0];
        out_d.data_offset = offset;
        out_d.data_length = (left < 32'(bs_eff)) ? left[15:0] : bs_eff;
      end
    end else begin
      failed_d         = 1'b1;
      out_d.error_code = ERR_UNEXPECTED;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tts_checker.sv =====
// Port-level checker for the TFTP transfer sequencer, bound to the top level.
// Depends on tts_pkg and tftp_transfer_sequencer_top.
`default_nettype none

module tts_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tready_o,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [tts_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import tts_pkg::*;

  out_beat_t res;
  assign res = out_beat_t'(m_axis_tdata_o);

  // A stalled result beat must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // The event side never stalls while the result side takes beats.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("event side stalled with result side ready");

  // A failure result carries nothing else.
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.error_code != ERR_NONE |->
      res.action == ACT_NONE && !res.accept_payload && !res.transfer_done)
    else $error("error result carries other fields");

  // A resend request has all other fields zero.
  a_resend_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.action == ACT_RESEND |->
      res.out_block == '0 && res.data_offset == '0 && res.data_length == '0 &&
      !res.accept_payload && !res.transfer_done)
    else $error("resend result has nonzero fields");

  // Sending data never coincides with completion or an accepted payload.
  a_data_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.action == ACT_SEND_DATA |->
      !res.transfer_done && !res.accept_payload && res.data_length != '0)
    else $error("data send combined with completion or receive");

endmodule

bind tftp_transfer_sequencer_top tts_checker u_tts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the TFTP transfer sequencer: directed read and write
// transfers, then random sessions, checked against an in-bench model of the sequencer.
// Depends on tts_pkg and tftp_transfer_sequencer_top.

module testbench;
  import tts_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned IdlePercent  = 22;
  localparam logic [15:0] BlockSizeMax = 16'd65464;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [1:0]          cfg_idx_i       = CFG_DIRECTION;
  logic [CfgDataW-1:0] cfg_wdata_i     = '0;
  logic                s_axis_tvalid_i = 1'b0;
  wire                 s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic [1:0]          s_axis_tuser_i  = OP_PACKET;
  wire                 m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  wire [OutDataW-1:0]  m_axis_tdata_o;

  // Model copy of the configuration registers.
  logic        cfg_send_file   = 1'b0;
  logic [15:0] cfg_block_size  = BlockSizeReset;
  logic [31:0] cfg_file_size   = '0;
  logic        cfg_main_client = 1'b1;

  // Model copy of the transfer state.
  logic [15:0] next_expected_block = '0;
  logic        xfer_finished       = 1'b0;
  logic        xfer_failed         = 1'b0;

  out_beat_t pending_replies[$];
  out_beat_t seen_reply;
  out_beat_t want_reply;
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  logic      no_idle        = 1'b0;

  tftp_transfer_sequencer_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [15:0] effective_block_size();
    return (cfg_block_size < BlockSizeMin) ? BlockSizeMin : cfg_block_size;
  endfunction

  // Advances the model by one event and returns the reply it predicts.
  function automatic out_beat_t sequencer_reply(op_e op, in_beat_t pkt);
    out_beat_t   r;
    logic [63:0] bsz;
    logic [63:0] nxt;
    logic [63:0] nblocks;
    logic [63:0] offs;
    logic [63:0] left;
    r   = '0;
    bsz = {48'd0, effective_block_size()};
    if (op == OP_START) begin
      xfer_finished       = 1'b0;
      xfer_failed         = 1'b0;
      next_expected_block = cfg_send_file ? 16'd0 : 16'd1;
    end else if (op != OP_UNUSED && !xfer_finished && !xfer_failed) begin
      if (op == OP_TIMEOUT) begin
        r.action = ACT_RESEND;
      end else if (pkt.packet_opcode == OPC_ERROR) begin
        xfer_failed  = 1'b1;
        r.error_code = ERR_PEER;
      end else if (!cfg_send_file) begin
        if (pkt.packet_opcode == OPC_OACK) begin
          r.action            = ACT_SEND_ACK;
          next_expected_block = 16'd1;
        end else if (pkt.packet_opcode == OPC_DATA) begin
          if (pkt.packet_block != next_expected_block) begin
            r.action = ACT_RESEND;
          end else begin
            r.accept_payload = 1'b1;
            if (cfg_main_client) begin
              r.action    = ACT_SEND_ACK;
              r.out_block = next_expected_block;
            end
            next_expected_block = next_expected_block + 16'd1;
            if ({48'd0, pkt.payload_bytes} < bsz) begin
              xfer_finished   = 1'b1;
              r.transfer_done = 1'b1;
            end
          end
        end else begin
          xfer_failed  = 1'b1;
          r.error_code = ERR_UNEXPECTED;
        end
      end else if (pkt.packet_opcode == OPC_ACK || pkt.packet_opcode == OPC_OACK) begin
        // The next block number keeps its carry so that an ACK of 65535 compares as 65536.
        nxt = (pkt.packet_opcode == OPC_ACK) ? {48'd0, pkt.packet_block} + 64'd1 : 64'd1;
        next_expected_block = nxt[15:0];
        nblocks = ({32'd0, cfg_file_size} + bsz - 64'd1) / bsz;
        if (nxt > nblocks) begin
          xfer_finished   = 1'b1;
          r.transfer_done = 1'b1;
        end else begin
          offs          = (nxt - 64'd1) * bsz;
          left          = {32'd0, cfg_file_size} - offs;
          r.action      = ACT_SEND_DATA;
          r.out_block   = nxt[15:0];
          r.data_offset = offs[31:0];
          r.data_length = (left < bsz) ? left[15:0] : bsz[15:0];
        end
      end else begin
        xfer_failed  = 1'b1;
        r.error_code = ERR_UNEXPECTED;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("mismatch in %s: got %0h, expected %0h", field, got, want);
      mismatch_count++;
    end
  endtask

  // Sends one event beat and records the reply predicted for it once it is taken.
  task automatic send_event(op_e op, logic [15:0] opcode, logic [15:0] blk,
                            logic [15:0] nbytes);
    in_beat_t pkt;
    pkt.packet_opcode = opcode;
    pkt.packet_block  = blk;
    pkt.payload_bytes = nbytes;
    if (!no_idle) begin
      while ($urandom_range(99) < IdlePercent) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pkt;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_replies.insert(pending_replies.size(), sequencer_reply(op, pkt));
  endtask

  task automatic drain_replies();
    s_axis_tvalid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic configure(logic send_file, logic [15:0] blk_bytes,
                           logic [31:0] file_size, logic acks_data);
    drain_replies();
    write_register(CFG_DIRECTION, {31'd0, send_file});
    write_register(CFG_BLOCK_SIZE, {16'd0, blk_bytes});
    write_register(CFG_FILE_SIZE, file_size);
    write_register(CFG_MAIN_CLIENT, {31'd0, acks_data});
    cfg_send_file   = send_file;
    cfg_block_size  = blk_bytes;
    cfg_file_size   = file_size;
    cfg_main_client = acks_data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic pick_random_config();
    logic [15:0] bsz;
    logic [31:0] fsz;
    int          eff;
    case ($urandom_range(5))
      0:       bsz = BlockSizeMin;
      1:       bsz = BlockSizeMax;
      2:       bsz = 16'($urandom_range(64, 8));
      3:       bsz = BlockSizeReset;
      4:       bsz = rnd16();
      default: bsz = 16'($urandom_range(7));
    endcase
    eff = (bsz < BlockSizeMin) ? int'(BlockSizeMin) : int'(bsz);
    case ($urandom_range(4))
      0:       fsz = '0;
      1:       fsz = '1;
      2:       fsz = $urandom();
      default: fsz = 32'(eff * $urandom_range(12) + $urandom_range(eff - 1));
    endcase
    configure(1'($urandom_range(1)), bsz, fsz, 1'($urandom_range(1)));
  endtask

  // Mostly well-formed lock-step sessions with random content, mixed with
  // timeouts, stale blocks, peer errors and stray opcodes.
  task automatic run_sessions(int target);
    int          sent;
    int          roll;
    logic [15:0] bsz;
    sent = 0;
    send_event(OP_START, rnd16(), rnd16(), rnd16());
    sent++;
    while (sent < target) begin
      bsz  = effective_block_size();
      roll = $urandom_range(99);
      if (xfer_finished || xfer_failed) begin
        if (roll < 30) send_event(roll[0] ? OP_TIMEOUT : OP_PACKET, rnd16(), rnd16(), rnd16());
        send_event(OP_START, rnd16(), rnd16(), rnd16());
        sent++;
      end else if (roll < 78) begin
        if (!cfg_send_file) begin
          if (next_expected_block == 16'd1 && roll < 6)
            send_event(OP_PACKET, OPC_OACK, rnd16(), rnd16());
          else if ($urandom_range(99) < 85)
            send_event(OP_PACKET, OPC_DATA, next_expected_block,
                       16'($urandom_range(65535, bsz)));
          else
            send_event(OP_PACKET, OPC_DATA, next_expected_block,
                       16'($urandom_range(bsz - 16'd1)));
        end else if (next_expected_block == 16'd0) begin
          send_event(OP_PACKET, (roll < 40) ? OPC_OACK : OPC_ACK, 16'd0, rnd16());
        end else if (roll < 70) begin
          send_event(OP_PACKET, OPC_ACK, next_expected_block, rnd16());
        end else begin
          // Duplicate ACK of the previous block.
          send_event(OP_PACKET, OPC_ACK, next_expected_block - 16'd1, rnd16());
        end
        sent++;
      end else if (roll < 88) begin
        send_event(OP_TIMEOUT, rnd16(), rnd16(), rnd16());
        sent++;
      end else if (roll < 93) begin
        send_event(OP_PACKET, cfg_send_file ? OPC_ACK : OPC_DATA, rnd16(), rnd16());
        sent++;
      end else if (roll < 95) begin
        send_event(OP_PACKET, OPC_ERROR, rnd16(), rnd16());
        sent++;
      end else if (roll < 97) begin
        send_event(OP_PACKET, cfg_send_file ? OPC_DATA : OPC_ACK, rnd16(), rnd16());
        sent++;
      end else if (roll < 99) begin
        send_event(OP_PACKET, rnd16(), rnd16(), rnd16());
        sent++;
      end else begin
        send_event(OP_UNUSED, rnd16(), rnd16(), rnd16());
      end
    end
  endtask

  // Out of reset the block behaves as a read already in progress at block 0.
  task automatic test_power_up_state();
    send_event(OP_TIMEOUT, rnd16(), rnd16(), rnd16());
    send_event(OP_UNUSED, 16'hffff, 16'hffff, 16'hffff);
    send_event(OP_PACKET, OPC_DATA, 16'd0, BlockSizeReset);
    send_event(OP_PACKET, OPC_DATA, 16'd7, BlockSizeReset);
  endtask

  task automatic test_read_transfers();
    // A block size below the minimum behaves as the minimum.
    configure(1'b0, 16'd3, '0, 1'b1);
    send_event(OP_START, '0, '0, '0);
    send_event(OP_PACKET, OPC_OACK, 16'd9, 16'd0);
    send_event(OP_PACKET, OPC_DATA, 16'd1, 16'd8);
    send_event(OP_PACKET, OPC_DATA, 16'd1, 16'd8);
    send_event(OP_TIMEOUT, '0, '0, '0);
    send_event(OP_PACKET, OPC_DATA, 16'd2, 16'd7);
    send_event(OP_PACKET, OPC_DATA, 16'd3, 16'd0);
    configure(1'b0, 16'hffff, '0, 1'b0);
    send_event(OP_START, 16'hffff, 16'hffff, 16'hffff);
    send_event(OP_PACKET, OPC_DATA, 16'd1, 16'hffff);
    send_event(OP_PACKET, OPC_DATA, 16'd2, 16'hfffe);
    send_event(OP_START, '0, '0, '0);
    send_event(OP_PACKET, OPC_ERROR, '0, '0);
    send_event(OP_TIMEOUT, '0, '0, '0);
    send_event(OP_START, '0, '0, '0);
    send_event(OP_PACKET, OPC_ACK, 16'd1, '0);
    send_event(OP_START, '0, '0, '0);
    send_event(OP_PACKET, 16'hffff, 16'd1, '0);
  endtask

  task automatic test_write_transfers();
    configure(1'b1, BlockSizeMin, 32'd20, 1'b1);
    send_event(OP_START, '0, '0, '0);
    send_event(OP_PACKET, OPC_OACK, '0, '0);
    send_event(OP_PACKET, OPC_ACK, 16'd1, '0);
    send_event(OP_PACKET, OPC_ACK, 16'd2, '0);
    send_event(OP_PACKET, OPC_ACK, 16'd3, '0);
    // An empty file completes on the first acknowledgment.
    configure(1'b1, BlockSizeMax, '0, 1'b0);
    send_event(OP_START, '0, '0, '0);
    send_event(OP_PACKET, OPC_OACK, '0, '0);
    // The block after 65535 wraps to 0 on the wire while the offset keeps going.
    configure(1'b1, BlockSizeMin, '1, 1'b1);
    send_event(OP_START, '0, '0, '0);
    send_event(OP_PACKET, OPC_ACK, 16'hffff, '0);
    send_event(OP_PACKET, OPC_DATA, 16'd1, 16'd8);
  endtask

  task automatic test_random_transfers(int phases, int per_phase);
    for (int i = 0; i < phases; i++) begin
      pick_random_config();
      run_sessions(per_phase);
    end
  endtask

  task automatic test_back_to_back();
    pick_random_config();
    no_idle = 1'b1;
    run_sessions(200);
    drain_replies();
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      if (rst_ni) m_axis_tready_i <= no_idle || ($urandom_range(99) >= IdlePercent);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        seen_reply = m_axis_tdata_o;
        if (pending_replies.size() == 0) begin
          flag_mismatch("result beat with none pending", 32'd1, 32'd0);
        end else begin
          want_reply = pending_replies.pop_front();
          flag_mismatch("action", 32'(seen_reply.action), 32'(want_reply.action));
          flag_mismatch("out_block", 32'(seen_reply.out_block), 32'(want_reply.out_block));
          flag_mismatch("data_offset", seen_reply.data_offset, want_reply.data_offset);
          flag_mismatch("data_length", 32'(seen_reply.data_length),
                        32'(want_reply.data_length));
          flag_mismatch("accept_payload", 32'(seen_reply.accept_payload),
                        32'(want_reply.accept_payload));
          flag_mismatch("transfer_done", 32'(seen_reply.transfer_done),
                        32'(want_reply.transfer_done));
          flag_mismatch("error_code", 32'(seen_reply.error_code),
                        32'(want_reply.error_code));
          flag_mismatch("pad", 32'(seen_reply.pad), 32'(want_reply.pad));
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_power_up_state();
    test_read_transfers();
    test_write_transfers();
    test_random_transfers(13, 110);
    test_back_to_back();
    drain_replies();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
